@@ design/co2vfd_pkg.sv @@
// Shared types, constants and reset values for the CO2 valve and fan dosing controller.
package co2vfd_pkg;

  localparam int TIME_W = 32;
  localparam int PPM_W  = 16;
  localparam int BAND_W = 10;
  localparam int WAIT_W = 20;
  localparam int MS_W   = 16;
  localparam int FAN_W  = 10;
  localparam int MAG_W  = 10;   // clamped deviation, 0..1000
  localparam int PROD_W = 26;   // deviation times pulse limit, below 2^26
  localparam int QUO_W  = 17;   // product / 1000
  localparam int DIVX_W = 23;   // product / 8
  localparam int RECIP_W = 24;
  localparam int DIVP_W = DIVX_W + RECIP_W;
  localparam int ADDR_W = 5;
  localparam int APB_W  = 32;

  localparam logic [PPM_W-1:0] STEP_PPM  = 16'd5;
  localparam logic [PPM_W-1:0] PULSE_DIV = 16'd1000;
  localparam logic [MS_W-1:0]  PULSE_MIN = 16'd50;
  localparam logic [PPM_W-1:0] NO_REMOTE = 16'hFFFF;
  localparam logic [PPM_W-1:0] NO_TARGET = 16'd0;

  // floor(x/125) = (x * ceil(2^30/125)) >> 30, exact for x < 2^23
  localparam logic [RECIP_W-1:0] DIV125_MUL = 24'd8589935;
  localparam int DIV125_SHIFT = 30;
  localparam int DIV8_SHIFT   = 3;

  localparam logic [BAND_W-1:0] BAND_RST      = 10'd50;
  localparam logic [WAIT_W-1:0] IDLE_WAIT_RST = 20'd5000;
  localparam logic [MS_W-1:0]   MAX_OPEN_RST  = 16'd2000;
  localparam logic [PPM_W-1:0]  MIN_TGT_RST   = 16'd200;
  localparam logic [PPM_W-1:0]  MAX_TGT_RST   = 16'd1500;
  localparam logic [FAN_W-1:0]  FAN_IDLE_RST  = 10'd0;
  localparam logic [FAN_W-1:0]  FAN_FULL_RST  = 10'd1000;
  localparam logic [PPM_W-1:0]  START_TGT_RST = 16'd1000;

  typedef enum logic [1:0] {
    VALVE_NONE  = 2'd0,
    VALVE_OPEN  = 2'd1,
    VALVE_CLOSE = 2'd2
  } valve_act_t;

  typedef enum logic [2:0] {
    REG_BAND      = 3'd0,
    REG_IDLE_WAIT = 3'd1,
    REG_MAX_OPEN  = 3'd2,
    REG_MIN_TGT   = 3'd3,
    REG_MAX_TGT   = 3'd4,
    REG_FAN_IDLE  = 3'd5,
    REG_FAN_FULL  = 3'd6,
    REG_START_TGT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [WAIT_W-1:0] idle_wait;
    logic [MS_W-1:0]   max_open;
    logic [PPM_W-1:0]  min_tgt;
    logic [PPM_W-1:0]  max_tgt;
    logic [FAN_W-1:0]  fan_idle;
    logic [FAN_W-1:0]  fan_full;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [PPM_W-1:0]  co2_ppm;
    logic              co2_valid;
    logic [PPM_W-1:0]  remote_target;
    logic              in_main_menu;
    logic              turn_up;
    logic              turn_down;
  } in_item_t;

  // tick decision, pulse length still as product and limit
  typedef struct packed {
    valve_act_t        valve_action;
    logic              fan_write;
    logic [FAN_W-1:0]  fan_speed;
    logic              valve_open_now;
    logic [PROD_W-1:0] pulse_prod;
    logic [MS_W-1:0]   pulse_max;
    logic [PPM_W-1:0]  target_now;
  } dec_t;

  typedef struct packed {
    valve_act_t        valve_action;
    logic              fan_write;
    logic [FAN_W-1:0]  fan_speed;
    logic              valve_open_now;
    logic [MS_W-1:0]   pulse_length_ms;
    logic [PPM_W-1:0]  target_now;
  } out_item_t;

endpackage

@@ design/co2_valve_fan_dosing_controller.sv @@
// Top level of the CO2 valve and fan dosing controller.
//
// One input beat is one control tick: time in ms, CO2 reading, remote
// setpoint and knob events. Each tick yields exactly one result beat with
// the valve command, the fan command, the pulse state and the setpoint.
// Configuration is an APB port, register i at byte address 4*i; pready is
// always high and writes land in the access cycle.
// Pipeline: input register, decision register, result register.
// Throughput is one beat per cycle while out_tready is high: the decision
// stage updates the controller state as it takes each beat, and the pulse
// time is kept as the product deviation*limit so the next tick compares
// against it without a divide; the divide by 1000 happens in the result
// stage.
// Each stage has its own valid bit and takes a new beat when it is empty or
// its successor moves, so a stalled receiver fills the pipe (three beats)
// before in_tready drops. Nothing is lost or repeated under stalls.
// Reset (rst_n low, synchronous) empties the pipe, restores the register
// reset values and loads the setpoint with the start target reset value.
module co2_valve_fan_dosing_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beat
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] now_ms, [47:32] co2_ppm, [63:48] remote_target,
  // [64] in_main_menu, [65] turn_up, [66] turn_down, [71:67] zero
  input  logic [71:0]                   in_tdata,
  // [0] co2_valid
  input  logic                          in_tuser,
  // result beat
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] valve_action, [11:2] fan_speed, [12] valve_open_now,
  // [28:13] pulse_length_ms, [44:29] target_now, [47:45] zero
  output logic [47:0]                   out_tdata,
  // [0] fan_write
  output logic                          out_tuser,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [co2vfd_pkg::ADDR_W-1:0] paddr,
  input  logic [co2vfd_pkg::APB_W-1:0]  pwdata,
  output logic [co2vfd_pkg::APB_W-1:0]  prdata,
  output logic                          pready
);
  import co2vfd_pkg::*;

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_vld_r;
  logic      core_rdy;
  dec_t      dec;
  logic      dec_vld;
  logic      pulse_rdy;
  out_item_t res;

  co2vfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  assign in_tready = !item_vld_r || core_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.now_ms        <= in_tdata[31:0];
      item_r.co2_ppm       <= in_tdata[47:32];
      item_r.co2_valid     <= in_tuser;
      item_r.remote_target <= in_tdata[63:48];
      item_r.in_main_menu  <= in_tdata[64];
      item_r.turn_up       <= in_tdata[65];
      item_r.turn_down     <= in_tdata[66];
    end
  end

  co2vfd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item     (item_r),
    .item_vld (item_vld_r),
    .dn_rdy   (pulse_rdy),
    .rdy      (core_rdy),
    .dec      (dec),
    .dec_vld  (dec_vld)
  );

  co2vfd_pulse u_pulse (
    .clk     (clk),
    .rst_n   (rst_n),
    .dec     (dec),
    .dec_vld (dec_vld),
    .out_rdy (out_tready),
    .rdy     (pulse_rdy),
    .res     (res),
    .res_vld (out_tvalid)
  );

  assign out_tdata = {3'b000, res.target_now, res.pulse_length_ms, res.valve_open_now,
                      res.fan_speed, res.valve_action};
  assign out_tuser = res.fan_write;

endmodule

@@ design/co2vfd_regs.sv @@
// APB configuration registers of the dosing controller.
module co2vfd_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [co2vfd_pkg::ADDR_W-1:0] paddr,
  input  logic [co2vfd_pkg::APB_W-1:0]  pwdata,
  output logic [co2vfd_pkg::APB_W-1:0]  prdata,
  output logic                          pready,
  output co2vfd_pkg::cfg_t              cfg
);
  import co2vfd_pkg::*;

  cfg_t              cfg_r;
  logic [PPM_W-1:0]  start_tgt_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band      <= BAND_RST;
      cfg_r.idle_wait <= IDLE_WAIT_RST;
      cfg_r.max_open  <= MAX_OPEN_RST;
      cfg_r.min_tgt   <= MIN_TGT_RST;
      cfg_r.max_tgt   <= MAX_TGT_RST;
      cfg_r.fan_idle  <= FAN_IDLE_RST;
      cfg_r.fan_full  <= FAN_FULL_RST;
      start_tgt_r     <= START_TGT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_BAND:      cfg_r.band      <= pwdata[BAND_W-1:0];
        REG_IDLE_WAIT: cfg_r.idle_wait <= pwdata[WAIT_W-1:0];
        REG_MAX_OPEN:  cfg_r.max_open  <= pwdata[MS_W-1:0];
        REG_MIN_TGT:   cfg_r.min_tgt   <= pwdata[PPM_W-1:0];
        REG_MAX_TGT:   cfg_r.max_tgt   <= pwdata[PPM_W-1:0];
        REG_FAN_IDLE:  cfg_r.fan_idle  <= pwdata[FAN_W-1:0];
        REG_FAN_FULL:  cfg_r.fan_full  <= pwdata[FAN_W-1:0];
        REG_START_TGT: start_tgt_r     <= pwdata[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BAND:      prdata = APB_W'(cfg_r.band);
      REG_IDLE_WAIT: prdata = APB_W'(cfg_r.idle_wait);
      REG_MAX_OPEN:  prdata = APB_W'(cfg_r.max_open);
      REG_MIN_TGT:   prdata = APB_W'(cfg_r.min_tgt);
      REG_MAX_TGT:   prdata = APB_W'(cfg_r.max_tgt);
      REG_FAN_IDLE:  prdata = APB_W'(cfg_r.fan_idle);
      REG_FAN_FULL:  prdata = APB_W'(cfg_r.fan_full);
      REG_START_TGT: prdata = APB_W'(start_tgt_r);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ design/co2vfd_core.sv @@
// Per-tick decision logic with the controller state and the decision register.
module co2vfd_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  co2vfd_pkg::cfg_t      cfg,
  input  co2vfd_pkg::in_item_t  item,
  input  logic                  item_vld,
  input  logic                  dn_rdy,
  output logic                  rdy,
  output co2vfd_pkg::dec_t      dec,
  output logic                  dec_vld
);
  import co2vfd_pkg::*;

  // controller state
  logic [PPM_W-1:0]  sp_r, sp_nxt;
  logic              pulse_r, pulse_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [MS_W-1:0]   pmax_r, pmax_nxt;

  dec_t              dec_r, dec_nxt;
  logic              dec_vld_r;
  logic              take;

  logic [PPM_W-1:0]  sp_base;
  logic [TIME_W-1:0] elapsed;
  logic [PROD_W-1:0] el_scaled;
  logic              close_ok;
  logic              wait_ok;
  logic              low;
  logic [PPM_W-1:0]  mag;
  logic              over;
  logic [MAG_W-1:0]  mag_c;
  logic [PROD_W-1:0] open_prod;
  logic [PPM_W:0]    up_v;
  logic [PPM_W-1:0]  dn_v;
  logic [PPM_W-1:0]  sp_k;

  assign rdy     = !dec_vld_r || dn_rdy;
  assign take    = item_vld && rdy;
  assign dec     = dec_r;
  assign dec_vld = dec_vld_r;

  always_comb begin
    sp_base = ((item.remote_target != NO_TARGET) && (item.remote_target != NO_REMOTE))
              ? item.remote_target : sp_r;
    elapsed = item.now_ms - last_r;

    // elapsed >= clamp(floor(prod/1000), 50, limit) without dividing:
    // floor(prod/1000) <= e  <=>  1000*e + 999 >= prod
    el_scaled = PROD_W'(elapsed[MS_W-1:0]) * PROD_W'(PULSE_DIV)
              + PROD_W'(PULSE_DIV - 16'd1);
    close_ok  = (elapsed >= TIME_W'(pmax_r))
             || ((elapsed >= TIME_W'(PULSE_MIN)) && (elapsed[TIME_W-1:MS_W] == '0)
                 && (el_scaled >= prod_r));
    wait_ok   = elapsed >= TIME_W'(cfg.idle_wait);

    low  = sp_base > item.co2_ppm;
    mag  = low ? (sp_base - item.co2_ppm) : (item.co2_ppm - sp_base);
    over = mag > PPM_W'(cfg.band);
    // a deviation of 1000 or more already saturates at the pulse limit
    mag_c     = (mag >= PULSE_DIV) ? PULSE_DIV[MAG_W-1:0] : mag[MAG_W-1:0];
    open_prod = PROD_W'(mag_c) * PROD_W'(cfg.max_open);

    dec_nxt.valve_action = VALVE_NONE;
    dec_nxt.fan_write    = 1'b0;
    dec_nxt.fan_speed    = '0;
    pulse_nxt = pulse_r;
    last_nxt  = last_r;
    prod_nxt  = prod_r;
    pmax_nxt  = pmax_r;

    if (item.co2_valid) begin
      if (pulse_r) begin
        if (close_ok) begin
          dec_nxt.valve_action = VALVE_CLOSE;
          dec_nxt.fan_write    = 1'b1;
          dec_nxt.fan_speed    = cfg.fan_idle;
          pulse_nxt = 1'b0;
          last_nxt  = item.now_ms;
        end
      end else if (wait_ok) begin
        dec_nxt.fan_write    = 1'b1;
        dec_nxt.valve_action = VALVE_CLOSE;
        dec_nxt.fan_speed    = cfg.fan_idle;
        if (over && !low) begin
          dec_nxt.fan_speed = cfg.fan_full;
        end else if (over) begin
          dec_nxt.valve_action = VALVE_OPEN;
          pulse_nxt = 1'b1;
          last_nxt  = item.now_ms;
          prod_nxt  = open_prod;
          pmax_nxt  = cfg.max_open;
        end
      end
    end

    // knob: raise first, then lower
    sp_k = sp_base;
    up_v = {1'b0, sp_k} + {1'b0, STEP_PPM};
    if (item.in_main_menu && item.turn_up) begin
      sp_k = (up_v < {1'b0, cfg.max_tgt}) ? up_v[PPM_W-1:0] : cfg.max_tgt;
    end
    dn_v = sp_k - STEP_PPM;
    if (item.in_main_menu && item.turn_down) begin
      if (sp_k < STEP_PPM) begin
        sp_k = cfg.min_tgt;
      end else begin
        sp_k = (dn_v > cfg.min_tgt) ? dn_v : cfg.min_tgt;
      end
    end
    sp_nxt = sp_k;

    dec_nxt.valve_open_now = pulse_nxt;
    dec_nxt.pulse_prod     = prod_nxt;
    dec_nxt.pulse_max      = pmax_nxt;
    dec_nxt.target_now     = sp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= START_TGT_RST;
      pulse_r   <= 1'b0;
      last_r    <= '0;
      prod_r    <= '0;
      pmax_r    <= '0;
      dec_vld_r <= 1'b0;
    end else begin
      if (take) begin
        sp_r    <= sp_nxt;
        pulse_r <= pulse_nxt;
        last_r  <= last_nxt;
        prod_r  <= prod_nxt;
        pmax_r  <= pmax_nxt;
      end
      if (rdy) begin
        dec_vld_r <= item_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

@@ design/co2vfd_pulse.sv @@
// Pulse length finish (product / 1000, clamp) and the result register.
module co2vfd_pulse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  co2vfd_pkg::dec_t      dec,
  input  logic                  dec_vld,
  input  logic                  out_rdy,
  output logic                  rdy,
  output co2vfd_pkg::out_item_t res,
  output logic                  res_vld
);
  import co2vfd_pkg::*;

  out_item_t         res_r, res_nxt;
  logic              res_vld_r;
  logic              load;
  logic [DIVX_W-1:0] div_x;
  logic [DIVP_W-1:0] div_p;
  logic [QUO_W-1:0]  quo;
  logic [QUO_W-1:0]  quo_lo;

  assign rdy     = !res_vld_r || out_rdy;
  assign load    = dec_vld && rdy;
  assign res     = res_r;
  assign res_vld = res_vld_r;

  always_comb begin
    // /1000 as /8 then reciprocal multiply for /125
    div_x  = dec.pulse_prod[PROD_W-1:DIV8_SHIFT];
    div_p  = DIVP_W'(div_x) * DIVP_W'(DIV125_MUL);
    quo    = div_p[DIV125_SHIFT +: QUO_W];
    quo_lo = (quo < QUO_W'(PULSE_MIN)) ? QUO_W'(PULSE_MIN) : quo;

    res_nxt.valve_action   = dec.valve_action;
    res_nxt.fan_write      = dec.fan_write;
    res_nxt.fan_speed      = dec.fan_speed;
    res_nxt.valve_open_now = dec.valve_open_now;
    // upper limit wins when it is below the minimum pulse
    res_nxt.pulse_length_ms = (quo_lo > QUO_W'(dec.pulse_max)) ? dec.pulse_max
                                                                : quo_lo[MS_W-1:0];
    res_nxt.target_now     = dec.target_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (rdy) begin
      res_vld_r <= dec_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench for the CO2 valve and fan dosing controller: stream ticks, APB setup, result scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import co2vfd_pkg::*;

  // The limit is far above the longest quiet stretch of a correct run: one
  // input gap plus one result stall plus the pipe and the settle time before
  // a register write.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_TICKS    = 147;
  localparam int NUM_PHASES     = 8;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // [31:0] now_ms, [47:32] co2_ppm, [63:48] remote_target,
  // [64] in_main_menu, [65] turn_up, [66] turn_down, [71:67] zero
  logic [71:0]         in_tdata   = '0;
  // [0] co2_valid
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [1:0] valve_action, [11:2] fan_speed, [12] valve_open_now,
  // [28:13] pulse_length_ms, [44:29] target_now, [47:45] zero
  logic [47:0]         out_tdata;
  // [0] fan_write
  logic                out_tuser;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ADDR_W-1:0]   paddr      = '0;
  logic [APB_W-1:0]    pwdata     = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  co2_valve_fan_dosing_controller DUT (.*);

  always #4 clk = ~clk;

  // Controller image: register copy plus the four state words.
  cfg_t              dose_cfg;
  logic [PPM_W-1:0]  start_tgt_reg;
  logic [PPM_W-1:0]  ctl_setpoint;
  logic              ctl_pulse_on;
  logic [TIME_W-1:0] ctl_last_act;
  logic [MS_W-1:0]   ctl_pulse_len;

  in_item_t  pending_ticks[$];     // ticks waiting for the driver
  out_item_t tick_outcomes_q[$];   // predicted results, oldest first
  in_item_t  drv_tick;             // tick currently on the input port

  int gap_pct   = 0;               // chance per beat of starting an input gap
  int stall_pct = 0;               // chance per cycle of starting a result stall
  int gap_left  = 0;
  int stall_left = 0;
  int mismatches = 0;
  int result_cnt = 0;
  int quiet_cycles = 0;

  // Stimulus generator's own view of time and setpoint. The setpoint does
  // not depend on the valve logic, so it can be tracked exactly.
  logic [TIME_W-1:0] gen_ms;
  logic [PPM_W-1:0]  gen_sp;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("[%0t] mismatch: %s at result %0d, got 0x%0h expected 0x%0h",
             $realtime, what, result_cnt, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic [PPM_W-1:0] take_remote(logic [PPM_W-1:0] sp, in_item_t t);
    return (t.remote_target != NO_TARGET && t.remote_target != NO_REMOTE) ?
           t.remote_target : sp;
  endfunction

  // Raise first, then lower. A raise clamps to the upper limit even when
  // that moves the setpoint down; a lower saturates at zero before the
  // lower limit is applied. Crossed limits fall out of the same order.
  function automatic logic [PPM_W-1:0] turn_knob(logic [PPM_W-1:0] sp, in_item_t t);
    logic [PPM_W:0]   raised;
    logic [PPM_W-1:0] lowered;
    if (t.in_main_menu) begin
      if (t.turn_up) begin
        raised = {1'b0, sp} + {1'b0, STEP_PPM};
        sp = (raised < {1'b0, dose_cfg.max_tgt}) ? raised[PPM_W-1:0] : dose_cfg.max_tgt;
      end
      if (t.turn_down) begin
        lowered = (sp >= STEP_PPM) ? sp - STEP_PPM : '0;
        sp = (lowered > dose_cfg.min_tgt) ? lowered : dose_cfg.min_tgt;
      end
    end
    return sp;
  endfunction

  // One control tick: remote setpoint, timed valve/fan decision, knob.
  function automatic out_item_t dose_tick(in_item_t t);
    out_item_t         r;
    logic [TIME_W-1:0] elapsed;
    logic              co2_low;
    logic [PPM_W-1:0]  dev;
    logic [47:0]       span;
    r = '0;
    r.valve_action = VALVE_NONE;
    ctl_setpoint = take_remote(ctl_setpoint, t);
    if (t.co2_valid) begin
      elapsed = t.now_ms - ctl_last_act;   // modular 32-bit time
      if (ctl_pulse_on) begin
        if (elapsed >= TIME_W'(ctl_pulse_len)) begin
          r.valve_action = VALVE_CLOSE;
          r.fan_write    = 1'b1;
          r.fan_speed    = dose_cfg.fan_idle;
          ctl_pulse_on   = 1'b0;
          ctl_last_act   = t.now_ms;
        end
      end else if (elapsed >= TIME_W'(dose_cfg.idle_wait)) begin
        co2_low = ctl_setpoint > t.co2_ppm;
        dev = co2_low ? ctl_setpoint - t.co2_ppm : t.co2_ppm - ctl_setpoint;
        // in band and too-high both close the valve; only the fan differs
        r.valve_action = VALVE_CLOSE;
        r.fan_write    = 1'b1;
        r.fan_speed    = dose_cfg.fan_idle;
        if (dev > PPM_W'(dose_cfg.band)) begin
          if (!co2_low) begin
            r.fan_speed = dose_cfg.fan_full;
          end else begin
            // floor(dev*max/1000), then the 50 ms floor, then the limit;
            // the limit wins when it is below 50
            span = (48'(dev) * 48'(dose_cfg.max_open)) / 48'(PULSE_DIV);
            if (span < 48'(PULSE_MIN)) span = 48'(PULSE_MIN);
            if (span > 48'(dose_cfg.max_open)) span = 48'(dose_cfg.max_open);
            r.valve_action = VALVE_OPEN;
            ctl_pulse_on   = 1'b1;
            ctl_pulse_len  = span[MS_W-1:0];
            ctl_last_act   = t.now_ms;
          end
        end
      end
    end
    ctl_setpoint     = turn_knob(ctl_setpoint, t);
    r.valve_open_now  = ctl_pulse_on;
    r.pulse_length_ms = ctl_pulse_len;
    r.target_now      = ctl_setpoint;
    return r;
  endfunction

  function automatic void store_register(reg_idx_t idx, logic [APB_W-1:0] val);
    case (idx)
      REG_BAND:      dose_cfg.band      = val[BAND_W-1:0];
      REG_IDLE_WAIT: dose_cfg.idle_wait = val[WAIT_W-1:0];
      REG_MAX_OPEN:  dose_cfg.max_open  = val[MS_W-1:0];
      REG_MIN_TGT:   dose_cfg.min_tgt   = val[PPM_W-1:0];
      REG_MAX_TGT:   dose_cfg.max_tgt   = val[PPM_W-1:0];
      REG_FAN_IDLE:  dose_cfg.fan_idle  = val[FAN_W-1:0];
      REG_FAN_FULL:  dose_cfg.fan_full  = val[FAN_W-1:0];
      REG_START_TGT: start_tgt_reg      = val[PPM_W-1:0];  // never read; reset loads START_TGT_RST
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: one tick per beat, random gaps between beats
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : tick_driver
    in_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // predict at acceptance, so the state follows the beat order
      if (in_tvalid && in_tready)
        tick_outcomes_q.push_back(dose_tick(drv_tick));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          nxt = pending_ticks.pop_front();
          drv_tick  <= nxt;
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, nxt.turn_down, nxt.turn_up, nxt.in_main_menu,
                        nxt.remote_target, nxt.co2_ppm, nxt.now_ms};
          in_tuser  <= nxt.co2_valid;
          if ($urandom_range(99) < gap_pct)
            gap_left = $urandom_range(13, 1);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: random stall bursts, field-by-field compare
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        result_cnt++;
        if (tick_outcomes_q.size() == 0) begin
          report_mismatch("result with no tick pending", out_tdata, 0);
        end else begin
          want = tick_outcomes_q.pop_front();
          if (out_tdata[1:0] !== want.valve_action)
            report_mismatch("valve_action", out_tdata[1:0], want.valve_action);
          if (out_tuser !== want.fan_write)
            report_mismatch("fan_write", out_tuser, want.fan_write);
          if (out_tdata[11:2] !== want.fan_speed)
            report_mismatch("fan_speed", out_tdata[11:2], want.fan_speed);
          if (out_tdata[12] !== want.valve_open_now)
            report_mismatch("valve_open_now", out_tdata[12], want.valve_open_now);
          if (out_tdata[28:13] !== want.pulse_length_ms)
            report_mismatch("pulse_length_ms", out_tdata[28:13], want.pulse_length_ms);
          if (out_tdata[44:29] !== want.target_now)
            report_mismatch("target_now", out_tdata[44:29], want.target_now);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(13, 1) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no beat on either side and no APB traffic.
  always @(posedge clk) begin : watchdog
    if (!rst_n || psel || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no beat for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // APB access: setup cycle, then access cycle until pready
  // ---------------------------------------------------------------------
  task automatic apb_write(reg_idx_t idx, logic [APB_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    store_register(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_readback(reg_idx_t idx, logic [APB_W-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // prdata sampled in the access cycle, before this edge's updates
    if (prdata !== want)
      report_mismatch({"readback of ", idx.name()}, prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register settings per phase: extremes first, then crossed limits,
  // a pulse limit under the 50 ms floor, a zero pulse, random ones, and
  // finally the reset values.
  task automatic program_phase(int p);
    logic [APB_W-1:0] v [8];
    case (p)
      0: v = '{0, 0, 50, 0, 65535, 1000, 0, 65535};
      1: v = '{1000, 600000, 60000, 65535, 0, 0, 1000, 0};
      2: v = '{3, 100, 10, 100, 900, 300, 700, 5};
      3: v = '{20, 0, 0, 0, 2000, 1, 999, 1500};
      NUM_PHASES - 1:
         v = '{BAND_RST, IDLE_WAIT_RST, MAX_OPEN_RST, MIN_TGT_RST,
               MAX_TGT_RST, FAN_IDLE_RST, FAN_FULL_RST, START_TGT_RST};
      default: begin
        v[0] = $urandom_range(120, 0);
        v[1] = $urandom_range(3000, 0);
        v[2] = $urandom_range(1) ? $urandom_range(60000, 50) : $urandom_range(400, 50);
        v[3] = $urandom_range(1500, 0);
        v[4] = ($urandom_range(3) == 0) ? $urandom_range(65535, 0)
                                        : $urandom_range(65535, v[3]);
        v[5] = $urandom_range(1000, 0);
        v[6] = $urandom_range(1000, 0);
        v[7] = $urandom_range(65535, 0);
      end
    endcase
    for (int i = 0; i < 8; i++) apb_write(reg_idx_t'(i), v[i]);
    for (int i = 0; i < 8; i++) apb_readback(reg_idx_t'(i), v[i]);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic void queue_tick(logic [TIME_W-1:0] now, logic [PPM_W-1:0] co2,
                                     bit valid, logic [PPM_W-1:0] remote,
                                     bit menu, bit up, bit down);
    in_item_t t;
    t.now_ms        = now;
    t.co2_ppm       = co2;
    t.co2_valid     = valid;
    t.remote_target = remote;
    t.in_main_menu  = menu;
    t.turn_up       = up;
    t.turn_down     = down;
    pending_ticks.push_back(t);
  endfunction

  // Mostly plausible time steps (short, about one pulse, about one wait)
  // and CO2 around the live setpoint, so pulses open and close; the rest
  // is arbitrary time jumps and raw readings.
  function automatic void queue_random_tick();
    in_item_t    t;
    int unsigned pick;
    int          lvl;
    int          off;
    pick = $urandom_range(99);
    if (pick < 4)       gen_ms = $urandom;
    else if (pick < 40) gen_ms += $urandom_range(100, 0);
    else if (pick < 70) gen_ms += $urandom_range(dose_cfg.max_open + 200, 0);
    else gen_ms += $urandom_range(dose_cfg.idle_wait + dose_cfg.idle_wait / 2 + 100, 0);
    t.now_ms = gen_ms;

    pick = $urandom_range(99);
    if (pick < 10)      t.remote_target = $urandom;
    else if (pick < 55) t.remote_target = NO_REMOTE;
    else                t.remote_target = NO_TARGET;
    gen_sp = take_remote(gen_sp, t);

    lvl  = int'(gen_sp);
    pick = $urandom_range(99);
    if (pick < 45) begin
      lvl = lvl - int'($urandom_range(dose_cfg.band + 1200, 0));
    end else if (pick < 70) begin
      lvl = lvl + int'($urandom_range(dose_cfg.band + 500, 0));
    end else if (pick < 85) begin
      // right at the band edge or one past it
      off = int'(dose_cfg.band) + int'($urandom_range(1, 0));
      lvl = $urandom_range(1) ? lvl + off : lvl - off;
    end else begin
      lvl = int'($urandom_range(65535, 0));
    end
    if (lvl < 0) lvl = 0;
    else if (lvl > 65535) lvl = 65535;
    t.co2_ppm      = lvl[PPM_W-1:0];
    t.co2_valid    = ($urandom_range(99) < 88);
    t.in_main_menu = ($urandom_range(99) < 60);
    t.turn_up      = ($urandom_range(3) == 0);
    t.turn_down    = ($urandom_range(3) == 0);
    gen_sp = turn_knob(gen_sp, t);
    pending_ticks.push_back(t);
  endfunction

  // Idle means: nothing queued, nothing on the port, nothing outstanding.
  // Checked at the falling edge, once the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_tvalid || tick_outcomes_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  int phase_gap   [NUM_PHASES] = '{25, 0, 50, 10, 35, 60, 0, 0};
  int phase_stall [NUM_PHASES] = '{30, 45, 0, 10, 60, 20, 0, 0};

  initial begin
    // reset image of the controller
    dose_cfg.band      = BAND_RST;
    dose_cfg.idle_wait = IDLE_WAIT_RST;
    dose_cfg.max_open  = MAX_OPEN_RST;
    dose_cfg.min_tgt   = MIN_TGT_RST;
    dose_cfg.max_tgt   = MAX_TGT_RST;
    dose_cfg.fan_idle  = FAN_IDLE_RST;
    dose_cfg.fan_full  = FAN_FULL_RST;
    start_tgt_reg      = START_TGT_RST;
    ctl_setpoint       = START_TGT_RST;
    ctl_pulse_on       = 1'b0;
    ctl_last_act       = '0;
    ctl_pulse_len      = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks under reset settings (band 50, wait 5000, limit 2000,
    // knob 200..1500, setpoint 1000).
    gap_pct   = 20;
    stall_pct = 20;
    queue_tick(32'hFFFF_FFFF, 16'hFFFF, 0, NO_REMOTE, 0, 1, 1);  // bad reading, menu off
    queue_tick(32'd100,   16'd900,   1, NO_TARGET, 1, 1, 1);     // wait running, both knob events
    queue_tick(32'd5000,  16'd200,   1, NO_REMOTE, 0, 0, 0);     // opens, 1600 ms
    queue_tick(32'd5100,  16'd200,   1, NO_TARGET, 0, 0, 0);     // pulse running
    queue_tick(32'd6599,  16'd200,   0, NO_TARGET, 0, 0, 0);     // bad reading mid pulse
    queue_tick(32'd6600,  16'd200,   1, NO_TARGET, 0, 0, 0);     // pulse over, closes
    queue_tick(32'd11599, 16'd2000,  1, NO_TARGET, 0, 0, 0);     // one ms short of the wait
    queue_tick(32'd11600, 16'd2000,  1, NO_TARGET, 0, 0, 0);     // too high: full fan
    queue_tick(32'd11601, 16'd1050,  1, NO_TARGET, 0, 0, 0);     // exactly on the band edge
    queue_tick(32'd11602, 16'd949,   1, NO_TARGET, 0, 0, 0);     // one past the edge, 102 ms
    queue_tick(32'd11704, 16'd0,     1, NO_TARGET, 0, 0, 0);     // closes
    queue_tick(32'd16704, 16'd0,     1, 16'd1,     1, 1, 0);     // smallest remote, raise
    queue_tick(32'd16705, 16'd0,     1, 16'hFFFE,  1, 0, 1);     // largest remote, pulse clamps
    queue_tick(32'd18705, 16'd0,     1, NO_TARGET, 1, 1, 0);     // raise above limit lowers
    queue_tick(32'd18706, 16'd202,   0, 16'd202,   1, 0, 1);     // lower stops at the floor
    queue_tick(32'd18707, 16'd0,     0, 16'd3,     1, 0, 1);     // lower from below 5
    queue_tick(32'hFFFF_FFF0, 16'd1000, 1, 16'd1000, 0, 0, 0);   // on target: idle
    queue_tick(32'hFFFF_FFF8, 16'd0, 1, NO_TARGET, 0, 0, 0);     // opens just before wrap
    queue_tick(32'h0000_07C7, 16'd0, 1, NO_TARGET, 0, 0, 0);     // one ms short across wrap
    queue_tick(32'h0000_07C8, 16'd0, 1, NO_TARGET, 0, 0, 0);     // closes across wrap
    queue_tick(32'h0000_07C9, 16'hFFFF, 1, NO_REMOTE, 1, 1, 0);  // wait running
    queue_tick(32'h8000_0000, 16'hFFFF, 1, NO_TARGET, 1, 1, 1);  // max reading: full fan
    wait_drained();

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      gen_sp    = ctl_setpoint;   // exact, the block is idle here
      gen_ms    = (p % 2 == 0) ? 32'hFFFF_FFFF - $urandom_range(200000, 0) : $urandom;
      for (int i = 0; i < PHASE_TICKS; i++) queue_random_tick();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
